// ===== rtl/spfm_pkg.sv =====
// Package for the single-precision multiplier: field widths and constants.
// Used by every module of the multiplier; depends on nothing.
`default_nettype none
package spfm_pkg;
    localparam int unsigned WordWidth   = 32;
    localparam int unsigned ExpWidth    = 8;
    localparam int unsigned FracWidth   = 23;
    localparam int unsigned HighWidth   = 13;
    localparam int unsigned LowWidth    = 11;
    localparam int unsigned PipeDepth   = 3;
    localparam logic [9:0]  ExpBiasAdj  = 10'd129;
    localparam logic [31:0] QuietNan    = 32'h7FC0_0000;

    // Stage 1 to stage 2 bundle.
    typedef struct packed {
        logic                 special;
        logic [31:0]          special_word;
        logic                 sign;
        logic [ExpWidth-1:0]  pre_exp;
        logic [25:0]          hh;
        logic [23:0]          hl;
        logic [23:0]          lh;
    } stage1_t;
endpackage
`default_nettype wire

// ===== rtl/single_precision_float_multiplier_unit.sv =====
// Top level of the single-precision multiplier.
// Depends on spfm_pkg, spfm_front and spfm_back.
`default_nettype none
// A new operand pair may be started in every cycle; busy is always low. Each
// product appears on product for one cycle with done high, after the start
// transfer has passed the three register stages (decode and partial
// products, partial product sum, normalisation). The receiver cannot stall,
// so every result must be taken in its cycle.
module single_precision_float_multiplier_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             done,
    output logic [31:0]      product
);
    import spfm_pkg::*;

    logic    v1;
    stage1_t s1;

    assign busy = 1'b0;

    spfm_front u_front (
        .clk(clk), .rst_n(rst_n), .valid_in(start && !busy),
        .a(operand_a), .b(operand_b), .valid_out(v1), .data_out(s1)
    );

    spfm_back u_back (
        .clk(clk), .rst_n(rst_n), .valid_in(v1), .data_in(s1),
        .valid_out(done), .word_out(product)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##3 done)
        else $error("start transfer did not give a result three cycles later");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("result without a matching start");
    a_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        v1 |-> ##2 done)
        else $error("stage one item lost");
endmodule
`default_nettype wire

// ===== rtl/spfm_front.sv =====
// First stage: special operand decode, exponent sum and partial products.
// Depends on spfm_pkg.
`default_nettype none
module spfm_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         valid_in,
    input  wire logic [31:0]                  a,
    input  wire logic [31:0]                  b,
    output logic                              valid_out,
    output spfm_pkg::stage1_t                 data_out
);
    import spfm_pkg::*;

    logic              sign;
    logic              a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
    logic [9:0]        exp_sum;
    logic [HighWidth-1:0] ha, hb;
    logic [LowWidth-1:0]  la, lb;
    stage1_t           s_next, s_reg;
    logic              valid_reg;

    always_comb
    begin
        sign   = a[31] ^ b[31];
        a_zero = a[30:0] == 31'd0;
        b_zero = b[30:0] == 31'd0;
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ha = {1'b1, a[22:11]};
        hb = {1'b1, b[22:11]};
        la = a[10:0];
        lb = b[10:0];
        exp_sum = {2'b00, a[30:23]} + {2'b00, b[30:23]} + ExpBiasAdj;

        s_next.sign    = sign;
        s_next.pre_exp = exp_sum[8] ? exp_sum[7:0] : 8'd0;
        s_next.hh      = ha * hb;
        s_next.hl      = ha * lb;
        s_next.lh      = la * hb;
        s_next.special = 1'b1;
        priority if (a_inf)
            s_next.special_word = b_zero ? QuietNan : {sign, a[30:0]};
        else if (b_inf)
            s_next.special_word = a_zero ? QuietNan : {sign, b[30:0]};
        else if (a_nan)
            s_next.special_word = a;
        else if (b_nan)
            s_next.special_word = b;
        else if (a_zero || b_zero)
            s_next.special_word = {sign, 31'd0};
        else
        begin
            s_next.special      = 1'b0;
            s_next.special_word = {sign, 31'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
            s_reg <= s_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = s_reg;
endmodule
`default_nettype wire

// ===== rtl/spfm_back.sv =====
// Second and third stages: partial product sum, then normalisation and packing.
// Depends on spfm_pkg.
`default_nettype none
module spfm_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid_in,
    input  spfm_pkg::stage1_t      data_in,
    output logic                   valid_out,
    output logic [31:0]            word_out
);
    import spfm_pkg::*;

    logic [25:0] sum_next, sum_reg;
    logic        special_reg, sign_reg, valid2_reg, valid3_reg;
    logic [31:0] special_word_reg, word_next, word_reg;
    logic [ExpWidth-1:0] pre_exp_reg, exp_field;
    logic [FracWidth-1:0] frac;

    // Truncated low parts; the sum stays below 2^26.
    assign sum_next = data_in.hh + {13'd0, data_in.hl[23:11]}
                    + {13'd0, data_in.lh[23:11]} + 26'd2;

    always_comb
    begin
        if (sum_reg[25])
        begin
            exp_field = pre_exp_reg + 8'd1;
            frac      = sum_reg[24:2];
        end
        else
        begin
            exp_field = pre_exp_reg;
            frac      = sum_reg[23:1];
        end
        word_next = special_reg ? special_word_reg : {sign_reg, exp_field, frac};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            valid2_reg <= valid_in;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            sum_reg          <= sum_next;
            special_reg      <= data_in.special;
            special_word_reg <= data_in.special_word;
            sign_reg         <= data_in.sign;
            pre_exp_reg      <= data_in.pre_exp;
        end
        if (valid2_reg)
            word_reg <= word_next;
    end

    assign valid_out = valid3_reg;
    assign word_out  = word_reg;
endmodule
`default_nettype wire
